/* rtl/crtb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package crtb_pkg;

	localparam int TIMER_COUNT = 4;
	localparam int COUNT_W     = 16;
	localparam int PRESCALE_W  = 10;
	localparam int PULSE_W     = 4;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	localparam int CTL_PRESCALE_LSB = 0;
	localparam int CTL_CASCADE_BIT  = 2;
	localparam int CTL_IRQ_BIT      = 6;
	localparam int CTL_ENABLE_BIT   = 7;

	typedef enum logic [1:0] {
		ACT_TICK    = 2'd0,
		ACT_RELOAD  = 2'd1,
		ACT_CONTROL = 2'd2,
		ACT_READ    = 2'd3
	} crtb_action_t;

	typedef struct packed {
		crtb_action_t  action;
		logic [1:0]    timer_index;
		logic [15:0]   write_data;
	} crtb_req_t;

	typedef struct packed {
		logic [15:0]        read_data;
		logic [PULSE_W-1:0] irq_pulse;
		logic [PULSE_W-1:0] overflow_pulse;
	} crtb_rsp_t;

	typedef struct packed {
		logic tick;
		logic wr_reload;
		logic wr_ctrl;
		logic cascade_ok;
	} crtb_timer_cmd_t;

	typedef struct packed {
		logic carry_out;
		logic irq;
	} crtb_timer_stat_t;

	function automatic logic [PRESCALE_W-1:0] period_mask(input logic [1:0] sel);
		logic [PRESCALE_W-1:0] m;
		unique case (sel)
			2'd0:    m = 10'h000;
			2'd1:    m = 10'h03F;
			2'd2:    m = 10'h0FF;
			default: m = 10'h3FF;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

/* rtl/crtb_timer.sv */
`timescale 1ns / 1ps
`default_nettype none
module crtb_timer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire crtb_pkg::crtb_timer_cmd_t     cmd,
	input  wire logic [15:0]                   data,
	input  wire logic                          carry_in,
	output crtb_pkg::crtb_timer_stat_t         stat,
	output logic [crtb_pkg::COUNT_W-1:0]       count
);
	import crtb_pkg::*;

	logic [COUNT_W-1:0]    count_q, reload_q;
	logic [PRESCALE_W-1:0] prescale_cnt_q;
	logic [1:0]            prescale_sel_q;
	logic                  cascade_q, irq_en_q, running_q;
	logic                  step, wrap;

	always_comb begin
		step = 1'b0;
		if (cmd.tick && running_q) begin
			if (cascade_q) begin
				step = carry_in;
			end else begin
				step = (prescale_cnt_q & period_mask(prescale_sel_q)) == '0;
			end
		end
		wrap = step && (count_q == COUNT_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			reload_q       <= '0;
			prescale_cnt_q <= '0;
			prescale_sel_q <= '0;
			cascade_q      <= 1'b0;
			irq_en_q       <= 1'b0;
			running_q      <= 1'b0;
		end else begin
			if (cmd.tick && running_q && !cascade_q) begin
				prescale_cnt_q <= prescale_cnt_q + 1'b1;
			end
			if (wrap) begin
				count_q <= reload_q;
			end else if (step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.wr_reload) begin
				reload_q <= data;
			end
			if (cmd.wr_ctrl) begin
				prescale_sel_q <= data[CTL_PRESCALE_LSB +: 2];
				cascade_q      <= data[CTL_CASCADE_BIT] & cmd.cascade_ok;
				irq_en_q       <= data[CTL_IRQ_BIT];
				running_q      <= data[CTL_ENABLE_BIT];
				if (!running_q && data[CTL_ENABLE_BIT]) begin
					count_q        <= reload_q;
					prescale_cnt_q <= '0;
				end
			end
		end
	end

	assign stat.carry_out = wrap;
	assign stat.irq       = wrap & irq_en_q;
	assign count          = count_q;

endmodule
`default_nettype wire

/* rtl/cascadable_reload_timer_bank.sv */
`timescale 1ns / 1ps
`default_nettype none
// Bank of four 16-bit up-counting reload timers with prescalers and a cascade
// chain. Every request (tick, reload write, control write or counter read)
// returns one response. The block takes one request per cycle unless a stalled
// response blocks it; each accepted request is held in the request register,
// which feeds the timer update and the response register, both written as the
// request advances. The cascade ripple through all timers is combinational.
module cascadable_reload_timer_bank (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire crtb_pkg::crtb_req_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output crtb_pkg::crtb_rsp_t      rsp
);
	import crtb_pkg::*;

	crtb_req_t  req_s1;
	logic       valid_s1;
	logic       adv_s1;
	crtb_rsp_t  rsp_q;
	logic       rsp_valid_q;

	crtb_timer_cmd_t    cmd [TIMER_COUNT];
	crtb_timer_stat_t   stat [TIMER_COUNT];
	logic [COUNT_W-1:0] count [TIMER_COUNT];
	logic [TIMER_COUNT:0] carry;
	logic [PULSE_W-1:0] ovf_vec, irq_vec;
	logic [COUNT_W-1:0] rd_data;
	logic               is_tick;

	assign adv_s1    = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !adv_s1;
	assign is_tick   = adv_s1 && (req_s1.action == ACT_TICK);
	assign carry[0]  = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_timer
		always_comb begin
			cmd[i].tick       = is_tick;
			cmd[i].wr_reload  = adv_s1 && (req_s1.action == ACT_RELOAD) &&
				(int'(req_s1.timer_index) == i);
			cmd[i].wr_ctrl    = adv_s1 && (req_s1.action == ACT_CONTROL) &&
				(int'(req_s1.timer_index) == i);
			cmd[i].cascade_ok = (i != 0);
		end

		crtb_timer u_timer (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd[i]),
			.data     (req_s1.write_data),
			.carry_in (carry[i]),
			.stat     (stat[i]),
			.count    (count[i])
		);

		assign carry[i+1] = stat[i].carry_out;
	end

	for (genvar k = 0; k < PULSE_W; k++) begin : g_pulse
		if (k < TIMER_COUNT) begin : g_live
			assign ovf_vec[k] = stat[k].carry_out;
			assign irq_vec[k] = stat[k].irq;
		end else begin : g_none
			assign ovf_vec[k] = 1'b0;
			assign irq_vec[k] = 1'b0;
		end
	end

	always_comb begin
		rd_data = '0;
		if (req_s1.action == ACT_READ) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				if (int'(req_s1.timer_index) == i) begin
					rd_data = count[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_q.read_data      <= rd_data;
			rsp_q.irq_pulse      <= is_tick ? irq_vec : '0;
			rsp_q.overflow_pulse <= is_tick ? ovf_vec : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1)
		else $error("request stalled with empty request register");

	a_irq_within_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp.irq_pulse & ~rsp.overflow_pulse) == '0))
		else $error("irq pulse without overflow");

	a_access_no_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && req_s1.action != ACT_TICK) |=>
			(rsp.overflow_pulse == '0 && rsp.irq_pulse == '0))
		else $error("pulse on register access");

	a_tick_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && req_s1.action != ACT_READ) |=> (rsp.read_data == '0))
		else $error("read data on non-read transfer");

endmodule
`default_nettype wire

/* tb/cascadable_reload_timer_bank_tb.sv */
`timescale 1ns / 1ps
module cascadable_reload_timer_bank_tb;
	import crtb_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 4;
	localparam int HOLD_CYCLES  = 200;
	localparam int STUCK_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 400;
	localparam int SETTLE       = 8;

	localparam logic [1:0] PRESCALE_1    = 2'd0;
	localparam logic [1:0] PRESCALE_64   = 2'd1;
	localparam logic [1:0] PRESCALE_256  = 2'd2;
	localparam logic [1:0] PRESCALE_1024 = 2'd3;

	localparam logic [PRESCALE_W-1:0] PRESCALE_MASK [4] = '{10'h000, 10'h03F, 10'h0FF, 10'h3FF};

	localparam logic [15:0] CTL_ENABLE  = 16'h0001 << CTL_ENABLE_BIT;
	localparam logic [15:0] CTL_IRQ     = 16'h0001 << CTL_IRQ_BIT;
	localparam logic [15:0] CTL_CASCADE = 16'h0001 << CTL_CASCADE_BIT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	crtb_req_t req_bus = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	crtb_rsp_t rsp_bus;

	logic hold_rsp = 1'b0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int error_count = 0;
	int stuck_cycles = 0;

	logic [COUNT_W-1:0]    tmr_count    [TIMER_COUNT] = '{default: '0};
	logic [COUNT_W-1:0]    tmr_reload   [TIMER_COUNT] = '{default: '0};
	logic [1:0]            tmr_psel     [TIMER_COUNT] = '{default: '0};
	logic                  tmr_cascade  [TIMER_COUNT] = '{default: '0};
	logic                  tmr_irq_en   [TIMER_COUNT] = '{default: '0};
	logic                  tmr_run      [TIMER_COUNT] = '{default: '0};
	logic [PRESCALE_W-1:0] tmr_prescale [TIMER_COUNT] = '{default: '0};

	crtb_rsp_t predicted_rsp[$];

	wire req_fire = req_valid && !req_stall;
	wire rsp_fire = rsp_valid && !rsp_stall;

	cascadable_reload_timer_bank u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_bus),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp_bus)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic crtb_rsp_t advance_timer_bank(input crtb_req_t item);
		crtb_rsp_t r;
		logic carry_in;
		logic carry_out;
		logic step;
		int i;
		int t;
		r = '0;
		t = int'(item.timer_index);
		if (item.action == ACT_TICK) begin
			carry_in = 1'b0;
			for (i = 0; i < TIMER_COUNT; i++) begin
				step = 1'b0;
				carry_out = 1'b0;
				if (tmr_run[i]) begin
					if (tmr_cascade[i]) begin
						step = carry_in;
					end else begin
						step = (tmr_prescale[i] & PRESCALE_MASK[tmr_psel[i]]) == '0;
						tmr_prescale[i] = tmr_prescale[i] + 1'b1;
					end
				end
				if (step) begin
					if (tmr_count[i] == COUNT_MAX) begin
						tmr_count[i] = tmr_reload[i];
						carry_out = 1'b1;
						if (i < PULSE_W) begin
							r.overflow_pulse[i] = 1'b1;
							r.irq_pulse[i] = tmr_irq_en[i];
						end
					end else begin
						tmr_count[i] = tmr_count[i] + 1'b1;
					end
				end
				carry_in = carry_out;
			end
		end else if (t < TIMER_COUNT) begin
			case (item.action)
				ACT_RELOAD: tmr_reload[t] = item.write_data;
				ACT_CONTROL: begin
					if (!tmr_run[t] && item.write_data[CTL_ENABLE_BIT]) begin
						tmr_count[t] = tmr_reload[t];
						tmr_prescale[t] = '0;
					end
					tmr_psel[t] = item.write_data[CTL_PRESCALE_LSB +: 2];
					tmr_cascade[t] = (t != 0) && item.write_data[CTL_CASCADE_BIT];
					tmr_irq_en[t] = item.write_data[CTL_IRQ_BIT];
					tmr_run[t] = item.write_data[CTL_ENABLE_BIT];
				end
				default: r.read_data = tmr_count[t];
			endcase
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, field, got, want);
		error_count++;
	endtask

	always @(posedge clk) begin
		crtb_rsp_t want;
		if (arst_n && rsp_fire) begin
			if (predicted_rsp.size() == 0) begin
				report_mismatch("unexpected transfer", rsp_bus.read_data, '0);
			end else begin
				want = predicted_rsp.pop_front();
				if (rsp_bus.read_data !== want.read_data)
					report_mismatch("read_data", rsp_bus.read_data, want.read_data);
				if (rsp_bus.irq_pulse !== want.irq_pulse)
					report_mismatch("irq_pulse", rsp_bus.irq_pulse, want.irq_pulse);
				if (rsp_bus.overflow_pulse !== want.overflow_pulse)
					report_mismatch("overflow_pulse", rsp_bus.overflow_pulse,
						want.overflow_pulse);
			end
		end
		if (arst_n && req_fire)
			predicted_rsp.push_back(advance_timer_bank(req_bus));
	end

	always @(posedge clk) begin
		rsp_stall <= hold_rsp || ($urandom_range(99) < rsp_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || req_fire || rsp_fire) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("[cascadable_reload_timer_bank] ERROR");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	function automatic crtb_req_t make_req(input crtb_action_t act, input int idx,
			input logic [15:0] data);
		crtb_req_t item;
		item.action = act;
		item.timer_index = idx[1:0];
		item.write_data = data;
		return item;
	endfunction

	function automatic crtb_req_t random_request();
		crtb_req_t item;
		int pick;
		pick = $urandom_range(99);
		item.timer_index = 2'($urandom_range(3));
		item.write_data = 16'($urandom);
		if (pick < 62) begin
			item.action = ACT_TICK;
		end else if (pick < 74) begin
			item.action = ACT_RELOAD;
			if ($urandom_range(1))
				item.write_data = COUNT_MAX - 16'($urandom_range(48));
		end else if (pick < 88) begin
			item.action = ACT_CONTROL;
			if ($urandom_range(3) != 0)
				item.write_data[CTL_ENABLE_BIT] = 1'b1;
			if ($urandom_range(9) < 7)
				item.write_data[CTL_PRESCALE_LSB +: 2] = PRESCALE_1;
			else if ($urandom_range(1))
				item.write_data[CTL_PRESCALE_LSB +: 2] = PRESCALE_64;
		end else begin
			item.action = ACT_READ;
		end
		return item;
	endfunction

	task automatic send_request(input crtb_req_t item);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_bus <= item;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(posedge clk);
		while (predicted_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(make_req(ACT_READ, 0, 16'h0000));
		send_request(make_req(ACT_READ, 3, 16'hFFFF));
		send_request(make_req(ACT_RELOAD, 0, 16'hFFFF));
		send_request(make_req(ACT_RELOAD, 1, 16'hFFFE));
		send_request(make_req(ACT_RELOAD, 2, 16'hFFFF));
		send_request(make_req(ACT_RELOAD, 3, 16'h0000));
		// timer 0 with cascade bit set and stray bits; timer 3 cascades but stays stopped
		send_request(make_req(ACT_CONTROL, 0, 16'hFF7C | CTL_ENABLE | CTL_IRQ));
		send_request(make_req(ACT_CONTROL, 1, CTL_CASCADE | CTL_IRQ | CTL_ENABLE));
		send_request(make_req(ACT_CONTROL, 2, CTL_CASCADE | CTL_ENABLE));
		send_request(make_req(ACT_CONTROL, 3, CTL_CASCADE | CTL_IRQ));
		repeat (3) send_request(make_req(ACT_TICK, 0, 16'h0000));
		send_request(make_req(ACT_READ, 1, 16'h0000));
		send_request(make_req(ACT_READ, 2, 16'h0000));
		send_request(make_req(ACT_RELOAD, 0, 16'h1234));
		send_request(make_req(ACT_READ, 0, 16'h0000));
		send_request(make_req(ACT_CONTROL, 0, 16'h0000));
		send_request(make_req(ACT_TICK, 3, 16'hFFFF));
		send_request(make_req(ACT_READ, 0, 16'h0000));
		send_request(make_req(ACT_CONTROL, 0, CTL_ENABLE | 16'(PRESCALE_1024)));
		send_request(make_req(ACT_CONTROL, 0, CTL_ENABLE | 16'(PRESCALE_256)));
		repeat (2) send_request(make_req(ACT_TICK, 0, 16'h0000));
		send_request(make_req(ACT_READ, 0, 16'h0000));
		send_request(make_req(ACT_READ, 3, 16'h0000));
		drain_responses();
	endtask

	task automatic test_random(input int items, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
		repeat (items) send_request(random_request());
		drain_responses();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		rsp_stall_pct <= 0;
		fork
			begin
				hold_rsp <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rsp <= 1'b0;
			end
		join_none
		repeat (60) send_request(random_request());
		drain_responses();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(PHASE_ITEMS, 0, 0);
		test_random(PHASE_ITEMS, 60, 0);
		test_random(PHASE_ITEMS, 0, 60);
		test_random(PHASE_ITEMS, 36, 36);
		test_backpressure();
		req_valid <= 1'b0;
		drain_responses();
		repeat (SETTLE) @(posedge clk);
		if (error_count == 0)
			$display("[cascadable_reload_timer_bank] OK");
		else
			$display("[cascadable_reload_timer_bank] ERROR");
		$finish;
	end

endmodule
